/* rtl/blu_pkg.sv */
// Shared types and constants of the backward LZ bitstream unpacker.
package blu_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 17;
  localparam int unsigned CNT_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_BITS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 3'd5;

  localparam logic [1:0] STATUS_BYTE     = 2'd0;
  localparam logic [1:0] STATUS_PENDING  = 2'd1;
  localparam logic [1:0] STATUS_FINISHED = 2'd2;

  localparam logic [3:0]  OFFSET_BITS_0_RST = 4'd9;
  localparam logic [3:0]  OFFSET_BITS_1_RST = 4'd10;
  localparam logic [3:0]  OFFSET_BITS_2_RST = 4'd12;
  localparam logic [3:0]  OFFSET_BITS_3_RST = 4'd12;
  localparam logic [4:0]  SKIP_BITS_RST     = 5'd0;
  localparam logic [16:0] OUTPUT_LENGTH_RST = 17'd65536;

  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_CONT,
    CMD_REJ_PEND,
    CMD_REJ_DONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic pending;
  } eng_status_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data;
    logic [15:0] pos;
    logic        fin;
  } res_entry_t;

  typedef struct packed {
    logic       valid;
    res_entry_t entry;
  } push_t;

  typedef struct packed {
    logic valid;
    logic pending;
  } item_end_t;

  function automatic logic [CNT_W-1:0] sat17(input logic [CNT_W:0] s);
    sat17 = s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

/* rtl/blu_ifs.sv */
// Channel interfaces: packed input words, result words, register writes.
interface blu_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] packed_byte;
  modport source (output valid, operation, packed_byte, input ready);
  modport sink   (input valid, operation, packed_byte, output ready);
endinterface

interface blu_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic [15:0] out_position;
  logic        last_of_run;
  logic        more_pending;
  logic        finished;
  modport source (output valid, status, out_byte, out_position, last_of_run,
                  more_pending, finished, input ready);
  modport sink   (input valid, status, out_byte, out_position, last_of_run,
                  more_pending, finished, output ready);
endinterface

interface blu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [blu_pkg::CFG_IDX_W-1:0] index;
  logic [blu_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/blu_front.sv */
// Front end: accepts input words, classifies them, holds one command.
module blu_front (
  input  logic                 clk,
  input  logic                 rst,
  blu_item_if.sink             item,
  input  blu_pkg::eng_status_t est,
  output logic                 cmd_valid,
  output blu_pkg::cmd_t        cmd,
  input  logic                 cmd_take,
  input  logic                 item_done
);

  logic busy;

  assign item.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        busy      <= 1'b1;
        cmd_valid <= 1'b1;
        cmd.data  <= item.packed_byte;
        if (est.done) begin
          cmd.kind <= blu_pkg::CMD_REJ_DONE;
        end else if (item.operation) begin
          cmd.kind <= blu_pkg::CMD_CONT;
        end else if (est.pending) begin
          cmd.kind <= blu_pkg::CMD_REJ_PEND;
        end else begin
          cmd.kind <= blu_pkg::CMD_LOAD;
        end
      end
      if (cmd_take) begin
        cmd_valid <= 1'b0;
      end
      if (item_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/blu_engine.sv */
// Back end: bit reader, token decoder, copy engine and history store.
module blu_engine #(
  parameter int unsigned OUTPUT_MAX    = 65536,
  parameter int unsigned HISTORY_DEPTH = 16384,
  parameter int unsigned RUN_PER_ITEM  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  blu_cfg_if.sink               cfg,
  input  logic                  cmd_valid,
  input  blu_pkg::cmd_t         cmd,
  output logic                  cmd_take,
  output blu_pkg::eng_status_t  est,
  output blu_pkg::push_t        push,
  output blu_pkg::item_end_t    item_end
);

  localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW      = $clog2(RUN_PER_ITEM + 1);
  localparam int unsigned LEN_TOP = (OUTPUT_MAX > 131071) ? 131071 : OUTPUT_MAX;

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_COPY, ST_REJ, ST_FIN} state_t;
  typedef enum logic [2:0] {
    PH_FLAG, PH_LITLEN, PH_LITBYTE, PH_MIDX, PH_LONGFLAG, PH_OFFSET, PH_MLEN
  } phase_t;

  state_t      st;
  phase_t      phase;
  logic [3:0]  obits [4];
  logic [16:0] out_len;
  logic [7:0]  bbuf;
  logic [3:0]  bleft;
  logic [4:0]  skip_rem;
  logic [13:0] acc;
  logic [3:0]  want;
  logic [1:0]  midx;
  logic [16:0] run_len;
  logic [13:0] moff;
  logic [16:0] wp;
  logic [16:0] copy_rem;
  logic        done;
  logic [CW-1:0] rcnt;
  logic        qval;
  logic        rej_pend;
  logic [7:0]  hist [HISTORY_DEPTH];
  logic [7:0]  hq;

  logic [16:0] clen;
  logic [17:0] q;
  logic        q_ok;
  logic [16:0] p;
  logic        stop;
  logic        emit_go;
  logic [7:0]  emit_byte;
  logic [16:0] run_dec;
  logic [17:0] mlen_sum;
  logic [16:0] mlen_sat;

  function automatic logic [16:0] clamp_len(input logic [16:0] v);
    if (v == 17'd0) begin
      clamp_len = 17'd1;
    end else if (v > 17'(LEN_TOP)) begin
      clamp_len = 17'(LEN_TOP);
    end else begin
      clamp_len = v;
    end
  endfunction

  function automatic logic [3:0] width_of(input logic [3:0] w);
    width_of = (w > 4'd14) ? 4'd14 : w;
  endfunction

  assign cfg.ready = 1'b1;
  assign cmd_take  = (st == ST_IDLE) && cmd_valid;

  assign clen     = clamp_len(out_len);
  assign q        = {1'b0, wp} + {4'd0, moff};
  assign q_ok     = q < {1'b0, clen};
  assign p        = wp - 17'd1;
  assign stop     = done || (rcnt == CW'(RUN_PER_ITEM));
  assign run_dec  = (run_len != 17'd0) ? run_len - 17'd1 : 17'd0;
  assign mlen_sum = {1'b0, run_len} + {15'd0, acc[2:0]};
  assign mlen_sat = blu_pkg::sat17(mlen_sum);

  always_comb begin
    emit_go   = 1'b0;
    emit_byte = acc[7:0];
    if (st == ST_COPY) begin
      emit_go   = 1'b1;
      emit_byte = qval ? hq : 8'd0;
    end else if (st == ST_RUN && !stop && copy_rem == 17'd0 && want == 4'd0
                 && phase == PH_LITBYTE) begin
      emit_go = 1'b1;
    end
  end

  always_comb begin
    push.valid = 1'b0;
    push.entry = '0;
    if (st == ST_REJ) begin
      push.valid        = 1'b1;
      push.entry.status = rej_pend ? blu_pkg::STATUS_PENDING : blu_pkg::STATUS_FINISHED;
      push.entry.fin    = !rej_pend;
    end else if (emit_go && wp != 17'd0) begin
      push.valid        = 1'b1;
      push.entry.status = blu_pkg::STATUS_BYTE;
      push.entry.data   = emit_byte;
      push.entry.pos    = p[15:0];
      push.entry.fin    = (p == 17'd0);
    end
  end

  assign est.done    = done;
  assign est.pending = (copy_rem != 17'd0) || (bleft != 4'd0);

  assign item_end.valid   = (st == ST_FIN);
  assign item_end.pending = (rej_pend && st == ST_FIN) ? 1'b1 :
                            (!done && ((copy_rem != 17'd0) || (bleft != 4'd0)));

  always_ff @(posedge clk) begin
    if (emit_go && wp != 17'd0) begin
      hist[p[AW-1:0]] <= emit_byte;
    end
    hq <= hist[q[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      phase     <= PH_FLAG;
      obits[0]  <= blu_pkg::OFFSET_BITS_0_RST;
      obits[1]  <= blu_pkg::OFFSET_BITS_1_RST;
      obits[2]  <= blu_pkg::OFFSET_BITS_2_RST;
      obits[3]  <= blu_pkg::OFFSET_BITS_3_RST;
      out_len   <= blu_pkg::OUTPUT_LENGTH_RST;
      bbuf      <= 8'd0;
      bleft     <= 4'd0;
      skip_rem  <= blu_pkg::SKIP_BITS_RST;
      acc       <= 14'd0;
      want      <= 4'd1;
      midx      <= 2'd0;
      run_len   <= 17'd0;
      moff      <= 14'd0;
      wp        <= clamp_len(blu_pkg::OUTPUT_LENGTH_RST);
      copy_rem  <= 17'd0;
      done      <= 1'b0;
      rcnt      <= '0;
      qval      <= 1'b0;
      rej_pend  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          blu_pkg::REG_OFFSET_BITS_0: obits[0] <= cfg.data[3:0];
          blu_pkg::REG_OFFSET_BITS_1: obits[1] <= cfg.data[3:0];
          blu_pkg::REG_OFFSET_BITS_2: obits[2] <= cfg.data[3:0];
          blu_pkg::REG_OFFSET_BITS_3: obits[3] <= cfg.data[3:0];
          blu_pkg::REG_SKIP_BITS: skip_rem <= cfg.data[4:0];
          blu_pkg::REG_OUTPUT_LENGTH: begin
            out_len <= cfg.data;
            wp      <= clamp_len(cfg.data);
          end
          default: ;
        endcase
      end

      case (st)
        ST_IDLE: begin
          if (cmd_valid) begin
            rcnt     <= '0;
            rej_pend <= 1'b0;
            case (cmd.kind)
              blu_pkg::CMD_LOAD: begin
                bbuf  <= cmd.data;
                bleft <= 4'd8;
                st    <= ST_RUN;
              end
              blu_pkg::CMD_CONT: st <= ST_RUN;
              blu_pkg::CMD_REJ_PEND: begin
                rej_pend <= 1'b1;
                st       <= ST_REJ;
              end
              default: st <= ST_REJ;
            endcase
          end
        end
        ST_RUN: begin
          if (stop) begin
            st <= ST_FIN;
          end else if (copy_rem != 17'd0) begin
            qval <= q_ok;
            st   <= ST_COPY;
          end else if (want == 4'd0) begin
            acc <= 14'd0;
            case (phase)
              PH_FLAG: begin
                want <= 4'd2;
                if (acc == 14'd0) begin
                  run_len <= 17'd0;
                  phase   <= PH_LITLEN;
                end else begin
                  phase <= PH_MIDX;
                end
              end
              PH_LITLEN: begin
                if (acc[1:0] == 2'd3) begin
                  run_len <= blu_pkg::sat17({1'b0, run_len} + 18'd3);
                  want    <= 4'd2;
                end else begin
                  run_len <= blu_pkg::sat17({1'b0, run_len} + {16'd0, acc[1:0]} + 18'd1);
                  phase   <= PH_LITBYTE;
                  want    <= 4'd8;
                end
              end
              PH_LITBYTE: begin
                run_len <= run_dec;
                if (run_dec == 17'd0) begin
                  phase <= PH_MIDX;
                  want  <= 4'd2;
                end else begin
                  want <= 4'd8;
                end
              end
              PH_MIDX: begin
                midx <= acc[1:0];
                if (acc[1:0] == 2'd3) begin
                  phase <= PH_LONGFLAG;
                  want  <= 4'd1;
                end else begin
                  phase <= PH_OFFSET;
                  want  <= width_of(obits[acc[1:0]]);
                end
              end
              PH_LONGFLAG: begin
                phase <= PH_OFFSET;
                want  <= acc[0] ? width_of(obits[3]) : 4'd7;
              end
              PH_OFFSET: begin
                moff <= acc;
                if (midx != 2'd3) begin
                  copy_rem <= {15'd0, midx} + 17'd2;
                  phase    <= PH_FLAG;
                  want     <= 4'd1;
                end else begin
                  run_len <= 17'd4;
                  phase   <= PH_MLEN;
                  want    <= 4'd3;
                end
              end
              PH_MLEN: begin
                run_len <= mlen_sat;
                if (acc[2:0] == 3'd7) begin
                  want <= 4'd3;
                end else begin
                  copy_rem <= blu_pkg::sat17({1'b0, mlen_sat} + 18'd1);
                  phase    <= PH_FLAG;
                  want     <= 4'd1;
                end
              end
              default: begin
                phase <= PH_FLAG;
                want  <= 4'd1;
              end
            endcase
          end else if (bleft != 4'd0) begin
            bbuf  <= {1'b0, bbuf[7:1]};
            bleft <= bleft - 4'd1;
            if (skip_rem != 5'd0) begin
              skip_rem <= skip_rem - 5'd1;
            end else begin
              acc  <= {acc[12:0], bbuf[0]};
              want <= want - 4'd1;
            end
          end else begin
            st <= ST_FIN;
          end
        end
        ST_COPY: begin
          copy_rem <= copy_rem - 17'd1;
          st       <= ST_RUN;
        end
        ST_REJ:  st <= ST_FIN;
        ST_FIN:  st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase

      // writing position zero ends the stream, dropping leftover work
      if (emit_go) begin
        if (wp == 17'd0) begin
          done <= 1'b1;
        end else begin
          wp   <= p;
          rcnt <= rcnt + CW'(1);
          if (p == 17'd0) begin
            done     <= 1'b1;
            copy_rem <= 17'd0;
            bleft    <= 4'd0;
          end
        end
      end
    end
  end

endmodule

/* rtl/blu_resbuf.sv */
// Result buffer: collects one input's results, then drains them with flags.
module blu_resbuf #(
  parameter int unsigned RUN_PER_ITEM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  blu_pkg::push_t     push,
  input  blu_pkg::item_end_t item_end,
  output logic               item_done,
  blu_result_if.source       result
);

  localparam int unsigned AW = (RUN_PER_ITEM > 1) ? $clog2(RUN_PER_ITEM) : 1;
  localparam int unsigned CW = $clog2(RUN_PER_ITEM + 1);

  typedef enum logic [1:0] {R_FILL, R_READ, R_SHOW} state_t;

  state_t              st;
  logic [CW-1:0]       wr;
  logic [CW-1:0]       rd;
  logic [CW-1:0]       total;
  logic                pend;
  blu_pkg::res_entry_t mem [RUN_PER_ITEM];
  blu_pkg::res_entry_t rq;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr[AW-1:0]] <= push.entry;
    end
    rq <= mem[rd[AW-1:0]];
  end

  assign result.valid        = (st == R_SHOW);
  assign result.status       = rq.status;
  assign result.out_byte     = rq.data;
  assign result.out_position = rq.pos;
  assign result.finished     = rq.fin;
  assign result.more_pending = pend;
  assign result.last_of_run  = (rd == total - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= R_FILL;
      wr        <= '0;
      rd        <= '0;
      total     <= '0;
      pend      <= 1'b0;
      item_done <= 1'b0;
    end else begin
      item_done <= 1'b0;
      case (st)
        R_FILL: begin
          if (push.valid) begin
            wr <= wr + CW'(1);
          end
          if (item_end.valid) begin
            pend  <= item_end.pending;
            total <= wr;
            rd    <= '0;
            if (wr == '0) begin
              item_done <= 1'b1;
            end else begin
              st <= R_READ;
            end
          end
        end
        R_READ: st <= R_SHOW;
        R_SHOW: begin
          if (result.ready) begin
            if (rd == total - CW'(1)) begin
              wr        <= '0;
              item_done <= 1'b1;
              st        <= R_FILL;
            end else begin
              rd <= rd + CW'(1);
              st <= R_READ;
            end
          end
        end
        default: st <= R_FILL;
      endcase
    end
  end

endmodule

/* rtl/backward_lz_bitstream_unpacker_top.sv */
// Top level of the backward LZ bitstream unpacker.
//
//   channel  dir  words
//   item     in   operation, packed_byte (packed stream, last byte first)
//   result   out  status, out_byte, out_position, last_of_run, more_pending,
//                 finished
//   cfg      in   index, data (register writes, always ready)
//
// One input word at a time. A packed byte is read bit by bit, plus a step per
// decoded field; a copied byte goes through the history store read port. Results
// then drain one at a time through the result buffer. Reset is synchronous; the
// history store is not cleared and needs none. A stalled result holds the next
// input word back; HISTORY_DEPTH must be a power of two, not checked by the block.
module backward_lz_bitstream_unpacker_top #(
  parameter int unsigned OUTPUT_MAX    = 65536,
  parameter int unsigned HISTORY_DEPTH = 16384,
  parameter int unsigned RUN_PER_ITEM  = 64
) (
  input  logic         clk,
  input  logic         rst,
  blu_item_if.sink     item,
  blu_result_if.source result,
  blu_cfg_if.sink      cfg
);

  logic                 cmd_valid;
  blu_pkg::cmd_t        cmd;
  logic                 cmd_take;
  blu_pkg::eng_status_t est;
  blu_pkg::push_t       push;
  blu_pkg::item_end_t   item_end;
  logic                 item_done;

  blu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .est       (est),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .item_done (item_done)
  );

  blu_engine #(
    .OUTPUT_MAX    (OUTPUT_MAX),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RUN_PER_ITEM  (RUN_PER_ITEM)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .est       (est),
    .push      (push),
    .item_end  (item_end)
  );

  blu_resbuf #(
    .RUN_PER_ITEM (RUN_PER_ITEM)
  ) u_resbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item_end  (item_end),
    .item_done (item_done),
    .result    (result)
  );

endmodule
